// ----- hw/rtl/ltc_pkg.sv -----
package ltc_pkg;

  typedef enum logic [2:0] {
    TT_INVALID = 3'd0,
    TT_BOOL    = 3'd1,
    TT_IDENT   = 3'd2,
    TT_INT     = 3'd3,
    TT_FLOAT   = 3'd4,
    TT_BLANK   = 3'd5,
    TT_STRING  = 3'd6,
    TT_SYMBOL  = 3'd7
  } tok_type_t;

  typedef struct packed {
    logic [7:0] tok_char;
    logic       no_char;
    logic       last_char;
    logic       ignore_symbols;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_USCR  = 8'h5f;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [2:0] COUNT_MAX = 3'd7;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic [7:0] true_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h74;
      2'd1:    b = 8'h72;
      2'd2:    b = 8'h75;
      default: b = 8'h65;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] false_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h66;
      3'd1:    b = 8'h61;
      3'd2:    b = 8'h6c;
      3'd3:    b = 8'h73;
      3'd4:    b = 8'h65;
      default: b = 8'h66;
    endcase
    return b;
  endfunction

  function automatic logic is_single_sym(input logic [7:0] c);
    logic hit;
    case (c)
      8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3e, 8'h3c, 8'h21, 8'h28, 8'h29, 8'h7b, 8'h7d,
      8'h3d, 8'h5b, 8'h5d, 8'h2c, 8'h2e, 8'h27, 8'h3b, 8'h5f, 8'h26, 8'h7c:
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_pair_sym(input logic [7:0] a, input logic [7:0] b);
    logic hit;
    case ({a, b})
      16'h3e3d, 16'h3c3d, 16'h3c2d, 16'h213d, 16'h2626,
      16'h7c7c, 16'h3d3d, 16'h2d3d, 16'h2b3d, 16'h2d3e:
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- hw/rtl/ltc_in_if.sv -----
interface ltc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tok_char;
  logic       no_char;
  logic       last_char;
  logic       ignore_symbols;

  modport source(output valid, output tok_char, output no_char, output last_char,
                 output ignore_symbols, input ready);
  modport sink(input valid, input tok_char, input no_char, input last_char,
               input ignore_symbols, output ready);
endinterface

// ----- hw/rtl/ltc_out_if.sv -----
interface ltc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_type;

  modport source(output valid, output token_type, input ready);
  modport sink(input valid, input token_type, output ready);
endinterface

// ----- hw/rtl/ltc_in_reg.sv -----
module ltc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  ltc_in_if.sink          in_ch,
  input  logic            s1_take,
  output ltc_pkg::stage_t s1
);
  import ltc_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;
  logic  in_take;

  assign in_ch.ready = !s1_valid_r || s1_take;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.tok_char       <= in_ch.tok_char;
      s1_item_r.no_char        <= in_ch.no_char;
      s1_item_r.last_char      <= in_ch.last_char;
      s1_item_r.ignore_symbols <= in_ch.ignore_symbols;
    end
  end

  assign s1.valid = s1_valid_r;
  assign s1.item  = s1_item_r;

endmodule

// ----- hw/rtl/ltc_scan.sv -----
module ltc_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  ltc_pkg::stage_t s1,
  output logic            s1_take,
  ltc_out_if.source       out_ch
);
  import ltc_pkg::*;

  typedef struct packed {
    logic [2:0] char_count;
    logic       ident_ok;
    logic       int_ok;
    logic       float_ok;
    logic       dot_seen;
    logic       prev_was_digit;
    logic       blank_ok;
    logic       starts_with_quote;
    logic       prev_was_quote;
    logic       true_match;
    logic       false_match;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } scan_state_t;

  localparam scan_state_t STATE_INIT = '{
    char_count: 3'd0, ident_ok: 1'b1, int_ok: 1'b1, float_ok: 1'b1,
    dot_seen: 1'b0, prev_was_digit: 1'b0, blank_ok: 1'b1,
    starts_with_quote: 1'b0, prev_was_quote: 1'b0, true_match: 1'b1,
    false_match: 1'b1, first_byte: 8'd0, second_byte: 8'd0
  };

  scan_state_t st_r;
  scan_state_t st_nxt;
  scan_state_t upd;
  tok_type_t   type_r;
  tok_type_t   type_nxt;
  tok_type_t   cls;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        emit;
  logic [7:0]  c;
  logic [2:0]  p;
  logic        dig;
  logic        lone_sign;
  logic        sym_hit;

  assign c   = s1.item.tok_char;
  assign p   = st_r.char_count;
  assign dig = is_digit(c);

  always_comb begin
    upd = st_r;
    if (!s1.item.no_char) begin
      if (p == 3'd0) begin
        upd.first_byte        = c;
        upd.ident_ok          = is_alpha(c) || (c == CH_USCR);
        upd.int_ok            = dig || is_sign(c);
        upd.float_ok          = dig || is_sign(c);
        upd.starts_with_quote = (c == CH_QUOTE);
      end else begin
        if (p == 3'd1) begin
          upd.second_byte = c;
        end
        if (!(dig || is_alpha(c) || (c == CH_USCR))) begin
          upd.ident_ok = 1'b0;
        end
        if (!dig) begin
          upd.int_ok = 1'b0;
        end
        if (c == CH_DOT) begin
          if (st_r.dot_seen) begin
            upd.float_ok = 1'b0;
          end
          upd.dot_seen = 1'b1;
        end else if (!dig) begin
          upd.float_ok = 1'b0;
        end
      end
      if (!is_blank(c)) begin
        upd.blank_ok = 1'b0;
      end
      if (p[2] || (true_byte(p[1:0]) != c)) begin
        upd.true_match = 1'b0;
      end
      if ((p >= 3'd5) || (false_byte(p) != c)) begin
        upd.false_match = 1'b0;
      end
      upd.prev_was_digit = dig;
      upd.prev_was_quote = (c == CH_QUOTE);
      if (p != COUNT_MAX) begin
        upd.char_count = p + 3'd1;
      end
    end
  end

  always_comb begin
    lone_sign = (upd.char_count == 3'd1) && is_sign(upd.first_byte);
    sym_hit   = ((upd.char_count == 3'd1) && is_single_sym(upd.first_byte)) ||
                ((upd.char_count == 3'd2) && is_pair_sym(upd.first_byte, upd.second_byte));
    if (upd.char_count == 3'd0) begin
      cls = TT_INVALID;
    end else begin
      if ((upd.true_match && (upd.char_count == 3'd4)) ||
          (upd.false_match && (upd.char_count == 3'd5))) begin
        cls = TT_BOOL;
      end else if (upd.ident_ok) begin
        cls = TT_IDENT;
      end else if (upd.int_ok && !lone_sign) begin
        cls = TT_INT;
      end else if (upd.float_ok && !lone_sign &&
                   ((upd.char_count == 3'd1) || upd.prev_was_digit)) begin
        cls = TT_FLOAT;
      end else if (upd.blank_ok) begin
        cls = TT_BLANK;
      end else if ((upd.char_count >= 3'd2) && upd.starts_with_quote &&
                   upd.prev_was_quote) begin
        cls = TT_STRING;
      end else begin
        cls = TT_INVALID;
      end
      if (!s1.item.ignore_symbols && sym_hit) begin
        cls = TT_SYMBOL;
      end
    end
  end

  assign s1_take = s1.valid && (!s1.item.last_char || !out_valid_r || out_ch.ready);
  assign emit    = s1_take && s1.item.last_char;

  always_comb begin
    st_nxt        = st_r;
    type_nxt      = type_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_take) begin
      st_nxt = emit ? STATE_INIT : upd;
    end
    if (emit) begin
      type_nxt      = cls;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_INIT;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.token_type = type_r;

endmodule

// ----- hw/rtl/lexical_token_classifier_core.sv -----
// Channel  Direction  Handshake     Payload
// in_ch    sink       valid/ready   tok_char[7:0], no_char, last_char, ignore_symbols
// out_ch   source     valid/ready   token_type[2:0]
//
// One character request is taken per cycle unless a last character waits on a held
// result. Path: input register, then classification into the result register.
// Reset is synchronous and active low; it clears the token state and both valid flags.
// Back pressure on out_ch holds the result register; while out_ready is high the
// input side never stalls, and non-last characters pass even while a result waits.
module lexical_token_classifier_core (
  input  logic      clk,
  input  logic      rst_n,
  ltc_in_if.sink    in_ch,
  ltc_out_if.source out_ch
);
  import ltc_pkg::*;

  stage_t s1;
  logic   s1_take;

  ltc_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .s1_take (s1_take),
    .s1      (s1)
  );

  ltc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1),
    .s1_take (s1_take),
    .out_ch  (out_ch)
  );

endmodule

// ----- hw/rtl/ltc_checker.sv -----
module ltc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_token_type
);

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;
  logic       inc;
  logic       dec;

  assign inc = in_valid && in_ready && in_last_char;
  assign dec = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (inc && !dec) begin
      pending_nxt = pending_r + 3'd1;
    end else if (dec && !inc) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_type))
    else $error("Result request dropped or changed while stalled.");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Input stalled although the result side is ready.");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("Result shown without a pending last character.");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd2)
    else $error("More tokens in flight than the pipeline can hold.");

endmodule

bind lexical_token_classifier_core ltc_checker u_ltc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last_char   (in_ch.last_char),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_token_type (out_ch.token_type)
);

// ----- test/lexical_token_classifier_core_tb.sv -----
`timescale 1ns / 1ps

module lexical_token_classifier_core_tb;
  import ltc_pkg::*;

  localparam string ID_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string WORD_CH = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  localparam string DIGITS = "0123456789";
  localparam string SIGNS = "+-";
  localparam string BLANKS = " \t\r\n";
  localparam string SYM_SINGLE = "+-*/><!(){}=[],.';_&|";
  localparam string SYM_PAIRS = ">=<=<-!=&&||==-=+=->";
  localparam string MIXED = "tfrueals0123456789._+- '\t";
  localparam string TRUE_WORD = "true";
  localparam string FALSE_WORD = "false";

  class token_class_scoreboard;
    tok_type_t expected_types[$];
    int errors;
    logic [2:0] n_chars;
    logic [7:0] head_byte;
    logic [7:0] second_byte;
    bit ident_ok, int_ok, float_ok, dot_seen, ends_digit, blank_ok;
    bit opens_quote, ends_quote, true_ok, false_ok;

    function new();
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      n_chars = 3'd0;
      head_byte = 8'd0;
      second_byte = 8'd0;
      ident_ok = 1'b1;
      int_ok = 1'b1;
      float_ok = 1'b1;
      dot_seen = 1'b0;
      ends_digit = 1'b0;
      blank_ok = 1'b1;
      opens_quote = 1'b0;
      ends_quote = 1'b0;
      true_ok = 1'b1;
      false_ok = 1'b1;
    endfunction

    function void take_char_request(logic [7:0] c, logic none, logic last, logic ign);
      bit dig, alpha, blank, lone_sign, sym;
      tok_type_t t;
      int k;
      if (!none) begin
        dig = (c >= "0") && (c <= "9");
        alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        blank = (c == " ") || (c == "\t") || (c == "\r") || (c == "\n");
        if (n_chars == 3'd0) begin
          head_byte = c;
          ident_ok = alpha || (c == CH_USCR);
          int_ok = dig || (c == CH_MINUS) || (c == CH_PLUS);
          float_ok = int_ok;
          opens_quote = (c == CH_QUOTE);
        end else begin
          if (n_chars == 3'd1) second_byte = c;
          if (!(dig || alpha || (c == CH_USCR))) ident_ok = 1'b0;
          if (!dig) int_ok = 1'b0;
          if (c == CH_DOT) begin
            if (dot_seen) float_ok = 1'b0;
            dot_seen = 1'b1;
          end else if (!dig) begin
            float_ok = 1'b0;
          end
        end
        if (!blank) blank_ok = 1'b0;
        if (n_chars >= 3'd4 || c != TRUE_WORD[n_chars]) true_ok = 1'b0;
        if (n_chars >= 3'd5 || c != FALSE_WORD[n_chars]) false_ok = 1'b0;
        ends_digit = dig;
        ends_quote = (c == CH_QUOTE);
        if (n_chars != COUNT_MAX) n_chars = n_chars + 3'd1;
      end
      if (last) begin
        t = TT_INVALID;
        if (n_chars != 3'd0) begin
          lone_sign = (n_chars == 3'd1) && ((head_byte == CH_MINUS) || (head_byte == CH_PLUS));
          if ((true_ok && n_chars == 3'd4) || (false_ok && n_chars == 3'd5)) t = TT_BOOL;
          else if (ident_ok) t = TT_IDENT;
          else if (int_ok && !lone_sign) t = TT_INT;
          else if (float_ok && !lone_sign && (n_chars == 3'd1 || ends_digit)) t = TT_FLOAT;
          else if (blank_ok) t = TT_BLANK;
          else if (n_chars >= 3'd2 && opens_quote && ends_quote) t = TT_STRING;
          sym = 1'b0;
          if (n_chars == 3'd1) begin
            for (k = 0; k < SYM_SINGLE.len(); k++)
              if (SYM_SINGLE[k] == head_byte) sym = 1'b1;
          end else if (n_chars == 3'd2) begin
            for (k = 0; k < SYM_PAIRS.len(); k += 2)
              if (SYM_PAIRS[k] == head_byte && SYM_PAIRS[k + 1] == second_byte) sym = 1'b1;
          end
          if (!ign && sym) t = TT_SYMBOL;
        end
        expected_types.push_back(t);
        clear_token();
      end
    endfunction

    function void check_token_type(logic [2:0] got);
      tok_type_t want;
      if (expected_types.size() == 0) begin
        $display("%0t: token type %0d arrived with none expected", $time, got);
        errors++;
      end else begin
        want = expected_types.pop_front();
        if (got !== want) begin
          $display("%0t: token type mismatch, expected %0d (%s), actual %0d",
                   $time, want, want.name(), got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ltc_in_if in_ch();
  ltc_out_if out_ch();
  token_class_scoreboard sb;
  logic [7:0] tok_buf[$];
  int src_idle_pct;
  int snk_idle_pct;
  int items_sent;
  bit noise_on;

  lexical_token_classifier_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("lexical_token_classifier_core verification failed");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_token_type(out_ch.token_type);
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.take_char_request(in_ch.tok_char, in_ch.no_char, in_ch.last_char,
                           in_ch.ignore_symbols);
  end

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic send_item(logic [7:0] c, logic none, logic last, logic ign);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tok_char <= c;
    in_ch.no_char <= none;
    in_ch.last_char <= last;
    in_ch.ignore_symbols <= ign;
    do @(posedge clk); while (!in_ch.ready);
    if (!none || last) items_sent++;
  endtask

  task automatic send_token(bit ign);
    bit tail_empty;
    tail_empty = (tok_buf.size() == 0) || (noise_on && $urandom_range(9) == 0);
    foreach (tok_buf[i]) begin
      if (noise_on && $urandom_range(19) == 0)
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, 1'($urandom_range(1)));
      if (!tail_empty && i == tok_buf.size() - 1)
        send_item(tok_buf[i], 1'b0, 1'b1, ign);
      else
        send_item(tok_buf[i], 1'b0, 1'b0, 1'($urandom_range(1)));
    end
    if (tail_empty) send_item(8'($urandom_range(255)), 1'b1, 1'b1, ign);
  endtask

  task automatic send_text(string s, bit ign);
    tok_buf.delete();
    for (int k = 0; k < s.len(); k++) tok_buf.push_back(s[k]);
    send_token(ign);
  endtask

  task automatic build_token();
    int n;
    string word_ch;
    tok_buf.delete();
    case ($urandom_range(9))
      0: begin
        word_ch = $urandom_range(1) ? TRUE_WORD : FALSE_WORD;
        for (int k = 0; k < word_ch.len(); k++) tok_buf.push_back(word_ch[k]);
        if ($urandom_range(3) == 0) tok_buf[$urandom_range(tok_buf.size() - 1)] = pick(WORD_CH);
        if ($urandom_range(4) == 0) void'(tok_buf.pop_back());
        if ($urandom_range(5) == 0) tok_buf.push_back(pick(WORD_CH));
      end
      1: begin
        tok_buf.push_back(pick(ID_HEAD));
        n = $urandom_range(0, 7);
        repeat (n) tok_buf.push_back(pick(WORD_CH));
        if ($urandom_range(3) == 0)
          tok_buf[$urandom_range(tok_buf.size() - 1)] = 8'($urandom_range(255));
      end
      2: begin
        if ($urandom_range(2) == 0) tok_buf.push_back(pick(SIGNS));
        n = $urandom_range(0, 6);
        repeat (n) tok_buf.push_back(pick(DIGITS));
        if (tok_buf.size() == 0) tok_buf.push_back(pick(DIGITS));
      end
      3: begin
        if ($urandom_range(3) == 0) tok_buf.push_back(pick(SIGNS));
        n = $urandom_range(0, 3);
        repeat (n) tok_buf.push_back(pick(DIGITS));
        tok_buf.push_back(CH_DOT);
        n = $urandom_range(0, 3);
        repeat (n) tok_buf.push_back(pick(DIGITS));
        if ($urandom_range(3) == 0) begin
          tok_buf.push_back(CH_DOT);
          tok_buf.push_back(pick(DIGITS));
        end
      end
      4: begin
        n = $urandom_range(1, 5);
        repeat (n) tok_buf.push_back(pick(BLANKS));
      end
      5: begin
        tok_buf.push_back(CH_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n) tok_buf.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(3) != 0) tok_buf.push_back(CH_QUOTE);
      end
      6: begin
        case ($urandom_range(3))
          0, 1: tok_buf.push_back(pick(SYM_SINGLE));
          2: begin
            n = 2 * $urandom_range(SYM_PAIRS.len() / 2 - 1);
            tok_buf.push_back(SYM_PAIRS[n]);
            tok_buf.push_back(SYM_PAIRS[n + 1]);
          end
          default: begin
            tok_buf.push_back(pick(SYM_SINGLE));
            tok_buf.push_back(pick(SYM_SINGLE));
          end
        endcase
      end
      7: begin
        n = $urandom_range(1, 9);
        repeat (n) tok_buf.push_back(8'($urandom_range(255)));
      end
      8: ;
      default: begin
        n = $urandom_range(1, 10);
        repeat (n) tok_buf.push_back(pick(MIXED));
      end
    endcase
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_types.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    items_sent = 0;
    noise_on = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.tok_char <= 8'd0;
    in_ch.no_char <= 1'b0;
    in_ch.last_char <= 1'b0;
    in_ch.ignore_symbols <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("", 1'b0);
    send_text("true", 1'b0);
    send_text("false", 1'b1);
    send_text("_", 1'b1);
    send_text("-", 1'b1);
    send_text("7", 1'b0);
    send_text("1.5", 1'b0);
    send_text(" ", 1'b0);
    send_text("''", 1'b0);
    send_text("->", 1'b0);
    send_text(">=", 1'b1);
    send_text("\377", 1'b0);
    drain_results();

    // The source pauses here until every outstanding token type has been returned.
    noise_on = 1'b1;
    items_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 30;
          snk_idle_pct = 54;
        end
        1: begin
          src_idle_pct = 54;
          snk_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      while (items_sent < 267 * (phase + 1)) begin
        build_token();
        send_token($urandom_range(3) == 0);
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("lexical_token_classifier_core verification clean");
    end else begin
      $display("lexical_token_classifier_core verification failed");
    end
    $finish;
  end

endmodule
